// File: rtl/cmc_pkg.sv
// Shared widths, register codes, types and divider step for the cursor motion cost block.
package cmc_pkg;

  localparam int CostFieldW = 12;
  localparam int CoordW     = 8;
  localparam int CostW      = (CostFieldW + CoordW + 2 > 15) ? CostFieldW + CoordW + 2 : 15;
  localparam int CostOutW   = 22;

  localparam int TargetW  = 8;
  localparam int FromW    = 9;
  localparam int CapW     = 8;
  localparam int VertW    = 48;
  localparam int HorzW    = 60;
  localparam int TabW     = 8;
  localparam int ColsW    = 8;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 60;

  localparam int UnreachCost = 10000;
  localparam int NearDist    = 10;
  localparam int TabReset    = 8;
  localparam int ColsReset   = 80;

  localparam int DivSteps  = 2;
  localparam int DivStages = (CoordW + DivSteps - 1) / DivSteps;
  localparam int DivW      = DivStages * DivSteps;
  localparam int Latency   = 7 + DivStages;

  typedef logic [CfgIdxW-1:0]    cfg_idx_t;
  typedef logic [CoordW-1:0]     coord_t;
  typedef logic [CoordW:0]       ntab_t;
  typedef logic [CostFieldW-1:0] cost_t;
  typedef logic [CostW-1:0]      acc_t;
  typedef logic [CostOutW-1:0]   cost_out_t;
  typedef logic [HorzW-1:0]      horz_t;
  typedef logic [DivW-1:0]       div_work_t;

  // Configuration register indexes
  localparam cfg_idx_t RegCapFlags   = cfg_idx_t'(0);
  localparam cfg_idx_t RegVertCosts  = cfg_idx_t'(1);
  localparam cfg_idx_t RegHorzCosts  = cfg_idx_t'(2);
  localparam cfg_idx_t RegTabWidth   = cfg_idx_t'(3);
  localparam cfg_idx_t RegScreenCols = cfg_idx_t'(4);

  // Capability bits
  localparam int CapLf        = 0;
  localparam int CapMultiDown = 1;
  localparam int CapUp        = 2;
  localparam int CapMultiUp   = 3;
  localparam int CapTab       = 4;
  localparam int CapBacktab   = 5;
  localparam int CapBackspace = 6;
  localparam int CapMultiLeft = 7;

  // Packed cost slots
  localparam int VcLf         = 0;
  localparam int VcMultiDown  = 1;
  localparam int VcUp         = 2;
  localparam int VcMultiUp    = 3;
  localparam int HcMultiRight = 0;
  localparam int HcMultiLeft  = 1;
  localparam int HcBackspace  = 2;
  localparam int HcTab        = 3;
  localparam int HcBacktab    = 4;

  typedef struct packed {
    logic [CapW-1:0] caps;
    cost_t           c_lf;
    cost_t           c_mdown;
    cost_t           c_up;
    cost_t           c_mup;
    cost_t           c_right;
    cost_t           c_left;
    cost_t           c_bs;
    cost_t           c_tab;
    cost_t           c_btab;
    coord_t          tw;
    coord_t          cols;
  } cfg_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t ox;
    coord_t oy;
    logic   unknown;
  } query_t;

  typedef struct packed {
    acc_t cost;
    logic unr;
  } vert_t;

  typedef struct packed {
    query_t q;
    vert_t  v;
  } ctx_t;

  typedef struct packed {
    logic  unknown;
    vert_t v;
    acc_t  hcost;
    logic  hunr;
  } fin_t;

  typedef struct packed {
    coord_t    rem;
    div_work_t work;
  } div_t;

  function automatic cost_t cost_field(horz_t costs, int idx);
    return cost_t'(costs >> (idx * CostFieldW));
  endfunction

  function automatic logic is_unknown(logic [FromW-1:0] v);
    logic [FromW+CoordW-1:0] w;
    w = {{CoordW{1'b0}}, v};
    return w[CoordW];
  endfunction

  // One restoring division step: bring in the next dividend bit, subtract if it fits.
  function automatic div_t div_step(coord_t rem, div_work_t work, coord_t d);
    logic [CoordW:0] trial;
    div_t            r;
    trial  = {rem, work[DivW-1]};
    r.work = {work[DivW-2:0], 1'b0};
    if (trial >= {1'b0, d}) begin
      trial     = trial - {1'b0, d};
      r.work[0] = 1'b1;
    end
    r.rem = trial[CoordW-1:0];
    return r;
  endfunction

endpackage

// File: rtl/cmc_vertical.sv
// Vertical motion cost: two stages, distance and product, then route selection.
module cmc_vertical (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cmc_pkg::cfg_t   cfg_i,
  input  logic            valid_i,
  input  cmc_pkg::query_t query_i,
  output logic            valid_o,
  output cmc_pkg::ctx_t   ctx_o
);

  logic              a_valid_q;
  cmc_pkg::query_t   a_query_q;
  logic              a_down_q, a_up_q, a_near_q;
  cmc_pkg::acc_t     a_mult_q;

  logic              down, up, near;
  cmc_pkg::coord_t   dv;
  cmc_pkg::cost_t    unit_cost;
  cmc_pkg::acc_t     mult;

  logic              b_valid_q;
  cmc_pkg::ctx_t     b_ctx_q;
  cmc_pkg::vert_t    vres;
  cmc_pkg::acc_t     cdo, cmup;

  always_comb begin
    down      = query_i.y > query_i.oy;
    up        = query_i.y < query_i.oy;
    dv        = down ? query_i.y - query_i.oy : query_i.oy - query_i.y;
    unit_cost = down ? cfg_i.c_lf : cfg_i.c_up;
    mult      = cmc_pkg::acc_t'(dv) * cmc_pkg::acc_t'(unit_cost);
    near      = dv < cmc_pkg::coord_t'(cmc_pkg::NearDist);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      a_query_q <= query_i;
      a_down_q  <= down;
      a_up_q    <= up;
      a_near_q  <= near;
      a_mult_q  <= mult;
    end
  end

  always_comb begin
    cdo       = cmc_pkg::acc_t'(cfg_i.c_mdown);
    cmup      = cmc_pkg::acc_t'(cfg_i.c_mup);
    vres.cost = '0;
    vres.unr  = 1'b0;
    if (a_down_q) begin
      if (cfg_i.caps[cmc_pkg::CapLf]) begin
        if (a_near_q && cdo < a_mult_q)             vres.cost = cdo;
        else if (!a_near_q && cdo + 1'b1 < a_mult_q) vres.cost = cdo + 1'b1;
        else                                         vres.cost = a_mult_q;
      end else if (cfg_i.caps[cmc_pkg::CapMultiDown]) begin
        vres.cost = a_near_q ? cdo : cdo + 1'b1;
      end else begin
        vres.unr = 1'b1;
      end
    end else if (a_up_q) begin
      if (cfg_i.caps[cmc_pkg::CapUp]) begin
        // far multi-up pays one extra character, but the compare skips it
        if (a_near_q && cmup < a_mult_q)       vres.cost = cmup;
        else if (!a_near_q && cmup < a_mult_q) vres.cost = cmup + 1'b1;
        else                                   vres.cost = a_mult_q;
      end else if (cfg_i.caps[cmc_pkg::CapMultiUp]) begin
        vres.cost = a_near_q ? cmup : cmup + 1'b1;
      end else begin
        vres.unr = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_valid_q) begin
      b_ctx_q.q <= a_query_q;
      b_ctx_q.v <= vres;
    end
  end

  assign valid_o = b_valid_q;
  assign ctx_o   = b_ctx_q;

endmodule

// File: rtl/cmc_divider.sv
// Pipelined two-lane divider: target and start columns over the tab width.
module cmc_divider (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cmc_pkg::coord_t divisor_i,
  input  logic            valid_i,
  input  cmc_pkg::ctx_t   ctx_i,
  output logic            valid_o,
  output cmc_pkg::ctx_t   ctx_o,
  output cmc_pkg::coord_t qx_o,
  output cmc_pkg::coord_t rx_o,
  output cmc_pkg::coord_t qo_o
);

  localparam int N = cmc_pkg::DivStages;

  logic [N-1:0]          valid_q;
  cmc_pkg::ctx_t         ctx_q   [N];
  cmc_pkg::coord_t       rem_q   [N][2];
  cmc_pkg::div_work_t    work_q  [N][2];

  // link[s] feeds stage s; link[N] is the pipeline output
  logic [N:0]            v_link;
  cmc_pkg::ctx_t         c_link  [N+1];
  cmc_pkg::coord_t       r_link  [N+1][2];
  cmc_pkg::div_work_t    w_link  [N+1][2];
  cmc_pkg::div_t         nxt     [N][2];

  always_comb begin
    v_link[0]    = valid_i;
    c_link[0]    = ctx_i;
    r_link[0][0] = '0;
    r_link[0][1] = '0;
    w_link[0][0] = cmc_pkg::div_work_t'(ctx_i.q.x);
    w_link[0][1] = cmc_pkg::div_work_t'(ctx_i.q.ox);
    for (int s = 0; s < N; s++) begin
      v_link[s+1] = valid_q[s];
      c_link[s+1] = ctx_q[s];
      for (int l = 0; l < 2; l++) begin
        r_link[s+1][l] = rem_q[s][l];
        w_link[s+1][l] = work_q[s][l];
      end
    end
  end

  always_comb begin
    for (int s = 0; s < N; s++) begin
      for (int l = 0; l < 2; l++) begin
        nxt[s][l].rem  = r_link[s][l];
        nxt[s][l].work = w_link[s][l];
        for (int k = 0; k < cmc_pkg::DivSteps; k++) begin
          nxt[s][l] = cmc_pkg::div_step(nxt[s][l].rem, nxt[s][l].work, divisor_i);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= v_link[N-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < N; s++) begin
      if (v_link[s]) begin
        ctx_q[s] <= c_link[s];
        for (int l = 0; l < 2; l++) begin
          rem_q[s][l]  <= nxt[s][l].rem;
          work_q[s][l] <= nxt[s][l].work;
        end
      end
    end
  end

  assign valid_o = v_link[N];
  assign ctx_o   = c_link[N];
  assign qx_o    = cmc_pkg::coord_t'(w_link[N][0]);
  assign rx_o    = r_link[N][0];
  assign qo_o    = cmc_pkg::coord_t'(w_link[N][1]);

endmodule

// File: rtl/cmc_horizontal.sv
// Horizontal motion cost: tab products, undershoot and overshoot prices, route choice.
module cmc_horizontal (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cmc_pkg::cfg_t   cfg_i,
  input  logic            valid_i,
  input  cmc_pkg::ctx_t   ctx_i,
  input  cmc_pkg::coord_t qx_i,
  input  cmc_pkg::coord_t rx_i,
  input  cmc_pkg::coord_t qo_i,
  output logic            valid_o,
  output cmc_pkg::fin_t   fin_o
);

  logic            bs;

  // stage M
  logic            right, left, near, fwd_room, back_room, tab_en;
  cmc_pkg::coord_t dh, twr, x, ox;
  cmc_pkg::ntab_t  nf, nb, n;
  cmc_pkg::cost_t  ct;
  cmc_pkg::acc_t   p, qv, hm;

  logic            m_valid_q;
  cmc_pkg::ctx_t   m_ctx_q;
  logic            m_right_q, m_left_q, m_near_q, m_fwd_room_q, m_back_room_q, m_tab_en_q;
  cmc_pkg::coord_t m_dh_q, m_rx_q;
  cmc_pkg::acc_t   m_p_q, m_qv_q, m_hm_q;

  // stage E
  cmc_pkg::acc_t   under, over, unreach;

  logic            e_valid_q;
  cmc_pkg::ctx_t   e_ctx_q;
  logic            e_right_q, e_left_q, e_near_q, e_tab_en_q;
  cmc_pkg::coord_t e_dh_q;
  cmc_pkg::acc_t   e_hm_q, e_under_q, e_over_q;

  // stage F
  cmc_pkg::acc_t   cri, cle, dh_a;
  logic            take_under, take_over, uok, ook;
  cmc_pkg::fin_t   fin;

  logic            f_valid_q;
  cmc_pkg::fin_t   f_fin_q;

  assign bs      = cfg_i.caps[cmc_pkg::CapBackspace];
  assign unreach = cmc_pkg::acc_t'(cmc_pkg::UnreachCost);

  always_comb begin
    x     = ctx_i.q.x;
    ox    = ctx_i.q.ox;
    right = x > ox;
    left  = x < ox;
    dh    = right ? x - ox : ox - x;
    // tab stops passed: forward floor(x/tw)-floor(ox/tw), back floor(ox/tw)-ceil(x/tw)+1
    nf    = cmc_pkg::ntab_t'(qx_i - qo_i);
    nb    = cmc_pkg::ntab_t'(qo_i) - cmc_pkg::ntab_t'(qx_i) + cmc_pkg::ntab_t'(1)
            - cmc_pkg::ntab_t'(rx_i != '0);
    n     = right ? nf : nb;
    ct    = right ? cfg_i.c_tab : cfg_i.c_btab;
    p     = cmc_pkg::acc_t'(ct) * cmc_pkg::acc_t'(n);
    twr   = cfg_i.tw - rx_i;
    qv    = cmc_pkg::acc_t'(cfg_i.c_bs) * cmc_pkg::acc_t'(twr);
    hm    = cmc_pkg::acc_t'(dh) * cmc_pkg::acc_t'(cfg_i.c_bs);
    near  = dh < cmc_pkg::coord_t'(cmc_pkg::NearDist);
    fwd_room  = ({1'b0, x} + {1'b0, cfg_i.tw}) < {1'b0, cfg_i.cols};
    back_room = x >= cfg_i.tw;
    tab_en    = (right && cfg_i.caps[cmc_pkg::CapTab])
             || (left && cfg_i.caps[cmc_pkg::CapBacktab]);
  end

  always_comb begin
    if (m_right_q) begin
      under = cmc_pkg::acc_t'(m_rx_q) + m_p_q;
      over  = (m_fwd_room_q && bs) ? m_qv_q + m_p_q + cmc_pkg::acc_t'(cfg_i.c_tab) : unreach;
    end else begin
      under = bs ? m_p_q + m_qv_q : unreach;
      over  = m_back_room_q ? m_p_q + cmc_pkg::acc_t'(cfg_i.c_btab) + cmc_pkg::acc_t'(m_rx_q)
                            : unreach;
    end
  end

  always_comb begin
    cri  = cmc_pkg::acc_t'(cfg_i.c_right);
    cle  = cmc_pkg::acc_t'(cfg_i.c_left);
    dh_a = cmc_pkg::acc_t'(e_dh_q);
    uok  = !bs || (e_under_q < e_hm_q);
    ook  = !bs || (e_over_q < e_hm_q);
    // the near-distance checks on the tab routes are implied by the far ones
    if (e_right_q) begin
      take_under = e_under_q <= cri && e_under_q < dh_a && e_over_q > e_under_q;
      take_over  = e_over_q <= cri && e_over_q < dh_a;
    end else begin
      // back-tab overshoot is priced against multi-right on purpose
      take_under = e_under_q <= cle && uok && e_over_q > e_under_q;
      take_over  = e_over_q <= cri && ook;
    end

    fin.unknown = e_ctx_q.q.unknown;
    fin.v       = e_ctx_q.v;
    fin.hcost   = '0;
    fin.hunr    = 1'b0;
    if (e_tab_en_q && take_under) begin
      fin.hcost = e_under_q;
    end else if (e_tab_en_q && take_over) begin
      fin.hcost = e_over_q;
    end else if (e_left_q) begin
      if (bs) begin
        if (cle < e_hm_q && e_near_q)  fin.hcost = cle;
        else if (cle + 1'b1 < e_hm_q)  fin.hcost = cle + 1'b1;
        else                           fin.hcost = e_hm_q;
      end else if (cfg_i.caps[cmc_pkg::CapMultiLeft]) begin
        fin.hcost = cle;
      end else begin
        fin.hunr = 1'b1;
      end
    end else if (e_right_q) begin
      if (cri < dh_a && e_near_q)    fin.hcost = cri;
      else if (cri + 1'b1 < dh_a)    fin.hcost = cri + 1'b1;
      else                           fin.hcost = dh_a;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      e_valid_q <= 1'b0;
      f_valid_q <= 1'b0;
    end else begin
      m_valid_q <= valid_i;
      e_valid_q <= m_valid_q;
      f_valid_q <= e_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      m_ctx_q       <= ctx_i;
      m_right_q     <= right;
      m_left_q      <= left;
      m_near_q      <= near;
      m_fwd_room_q  <= fwd_room;
      m_back_room_q <= back_room;
      m_tab_en_q    <= tab_en;
      m_dh_q        <= dh;
      m_rx_q        <= rx_i;
      m_p_q         <= p;
      m_qv_q        <= qv;
      m_hm_q        <= hm;
    end
    if (m_valid_q) begin
      e_ctx_q    <= m_ctx_q;
      e_right_q  <= m_right_q;
      e_left_q   <= m_left_q;
      e_near_q   <= m_near_q;
      e_tab_en_q <= m_tab_en_q;
      e_dh_q     <= m_dh_q;
      e_hm_q     <= m_hm_q;
      e_under_q  <= under;
      e_over_q   <= over;
    end
    if (e_valid_q) begin
      f_fin_q <= fin;
    end
  end

  assign valid_o = f_valid_q;
  assign fin_o   = f_fin_q;

endmodule

// File: rtl/cursor_motion_cost.sv
// Top level of the relative cursor motion cost estimator.
//
// Query channel: a transaction is taken at each rising edge with start high;
// busy is always low, so a new query may follow in every cycle. The block
// keeps no state between queries.
// Result channel: done_o is driven by the output register and stays high for
// exactly one cycle with cost_o and unreachable_o. Results leave in query
// order, one per cycle at most. The receiver cannot stall.
// Pipeline: input register, two vertical stages, four divider stages (two
// quotient bits each, tab width divides target and start column in parallel),
// three horizontal stages and the output register.
// Configuration channel: cfg_ready_o is always high; a transaction writes
// register cfg_index_i, indexes beyond the list are dropped. Write only while
// no query is in flight.
// Reset: clears all pipeline valid bits and returns the registers to their
// defaults (no capabilities, zero costs, tab width 8, 80 columns).
module cursor_motion_cost (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [cmc_pkg::TargetW-1:0]         target_col_i,
  input  logic [cmc_pkg::TargetW-1:0]         target_row_i,
  input  logic signed [cmc_pkg::FromW-1:0]    from_col_i,
  input  logic signed [cmc_pkg::FromW-1:0]    from_row_i,
  output logic                                done_o,
  output logic [cmc_pkg::CostOutW-1:0]        cost_o,
  output logic                                unreachable_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [cmc_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [cmc_pkg::CfgDataW-1:0]        cfg_data_i
);

  logic [cmc_pkg::CapW-1:0]  cap_q;
  logic [cmc_pkg::VertW-1:0] vert_q;
  cmc_pkg::horz_t            horz_q;
  logic [cmc_pkg::TabW-1:0]  tab_q;
  logic [cmc_pkg::ColsW-1:0] cols_q;
  cmc_pkg::cfg_t             cfg;
  cmc_pkg::coord_t           tw_raw;

  logic                      accept;
  logic                      in_valid_q;
  cmc_pkg::query_t           in_query_q;

  logic                      vert_valid;
  cmc_pkg::ctx_t             vert_ctx;
  logic                      div_valid;
  cmc_pkg::ctx_t             div_ctx;
  cmc_pkg::coord_t           qx, rx, qo;
  logic                      hor_valid;
  cmc_pkg::fin_t             hor_fin;

  logic                      unr;
  logic                      out_valid_q;
  cmc_pkg::cost_out_t        out_cost_q;
  logic                      out_unr_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= '0;
      vert_q <= '0;
      horz_q <= '0;
      tab_q  <= cmc_pkg::TabW'(cmc_pkg::TabReset);
      cols_q <= cmc_pkg::ColsW'(cmc_pkg::ColsReset);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        cmc_pkg::RegCapFlags:   cap_q  <= cfg_data_i[cmc_pkg::CapW-1:0];
        cmc_pkg::RegVertCosts:  vert_q <= cfg_data_i[cmc_pkg::VertW-1:0];
        cmc_pkg::RegHorzCosts:  horz_q <= cfg_data_i[cmc_pkg::HorzW-1:0];
        cmc_pkg::RegTabWidth:   tab_q  <= cfg_data_i[cmc_pkg::TabW-1:0];
        cmc_pkg::RegScreenCols: cols_q <= cfg_data_i[cmc_pkg::ColsW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    tw_raw      = cmc_pkg::coord_t'(tab_q);
    cfg.caps    = cap_q;
    cfg.c_lf    = cmc_pkg::cost_field(cmc_pkg::horz_t'(vert_q), cmc_pkg::VcLf);
    cfg.c_mdown = cmc_pkg::cost_field(cmc_pkg::horz_t'(vert_q), cmc_pkg::VcMultiDown);
    cfg.c_up    = cmc_pkg::cost_field(cmc_pkg::horz_t'(vert_q), cmc_pkg::VcUp);
    cfg.c_mup   = cmc_pkg::cost_field(cmc_pkg::horz_t'(vert_q), cmc_pkg::VcMultiUp);
    cfg.c_right = cmc_pkg::cost_field(horz_q, cmc_pkg::HcMultiRight);
    cfg.c_left  = cmc_pkg::cost_field(horz_q, cmc_pkg::HcMultiLeft);
    cfg.c_bs    = cmc_pkg::cost_field(horz_q, cmc_pkg::HcBackspace);
    cfg.c_tab   = cmc_pkg::cost_field(horz_q, cmc_pkg::HcTab);
    cfg.c_btab  = cmc_pkg::cost_field(horz_q, cmc_pkg::HcBacktab);
    // zero tab width acts as one
    cfg.tw      = (tw_raw == '0) ? cmc_pkg::coord_t'(1) : tw_raw;
    cfg.cols    = cmc_pkg::coord_t'(cols_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= accept;
      out_valid_q <= hor_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_query_q.x       <= cmc_pkg::coord_t'(target_col_i);
      in_query_q.y       <= cmc_pkg::coord_t'(target_row_i);
      in_query_q.ox      <= cmc_pkg::coord_t'($unsigned(from_col_i));
      in_query_q.oy      <= cmc_pkg::coord_t'($unsigned(from_row_i));
      in_query_q.unknown <= cmc_pkg::is_unknown(from_col_i) || cmc_pkg::is_unknown(from_row_i);
    end
  end

  cmc_vertical u_vertical (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (in_valid_q),
    .query_i (in_query_q),
    .valid_o (vert_valid),
    .ctx_o   (vert_ctx)
  );

  cmc_divider u_divider (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .divisor_i (cfg.tw),
    .valid_i   (vert_valid),
    .ctx_i     (vert_ctx),
    .valid_o   (div_valid),
    .ctx_o     (div_ctx),
    .qx_o      (qx),
    .rx_o      (rx),
    .qo_o      (qo)
  );

  cmc_horizontal u_horizontal (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (div_valid),
    .ctx_i   (div_ctx),
    .qx_i    (qx),
    .rx_i    (rx),
    .qo_i    (qo),
    .valid_o (hor_valid),
    .fin_o   (hor_fin)
  );

  assign unr = hor_fin.unknown || hor_fin.v.unr || hor_fin.hunr;

  always_ff @(posedge clk_i) begin
    if (hor_valid) begin
      out_unr_q  <= unr;
      out_cost_q <= unr ? cmc_pkg::cost_out_t'(cmc_pkg::UnreachCost)
                        : cmc_pkg::cost_out_t'(hor_fin.v.cost + hor_fin.hcost);
    end
  end

  assign done_o        = out_valid_q;
  assign cost_o        = out_cost_q;
  assign unreachable_o = out_unr_q;

endmodule

// File: rtl/cmc_checker.sv
// Port-level checks for the cursor motion cost block, bound to the top level.
module cmc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             start,
  input logic                             busy,
  input logic signed [cmc_pkg::FromW-1:0] from_col_i,
  input logic signed [cmc_pkg::FromW-1:0] from_row_i,
  input logic                             done_o,
  input logic [cmc_pkg::CostOutW-1:0]     cost_o,
  input logic                             unreachable_o
);

  // every result comes from a transaction taken a fixed latency earlier
  a_done_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, cmc_pkg::Latency))
    else $error("result strobe without a matching query");

  a_query_gives_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##(cmc_pkg::Latency) done_o)
    else $error("query lost in the pipeline");

  a_unreach_cost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && unreachable_o) |-> cost_o == cmc_pkg::cost_out_t'(cmc_pkg::UnreachCost))
    else $error("unreachable result with wrong cost");

  a_unknown_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (cmc_pkg::is_unknown(from_col_i) || cmc_pkg::is_unknown(from_row_i)))
    |-> ##(cmc_pkg::Latency) (done_o && unreachable_o))
    else $error("unknown start position not flagged");

endmodule

bind cursor_motion_cost cmc_checker u_cmc_checker (.*);

// File: test/cursor_motion_cost_test.sv
// Self-checking bench for the cursor motion cost block, checked against a local cost predictor.
module cursor_motion_cost_test;
  timeunit 1ns;
  timeprecision 1ps;
  import cmc_pkg::*;

  localparam int IdleLimit   = 500;
  localparam int PhaseCount  = 13;
  localparam int PhaseItems  = 120;
  localparam int CoordMax    = (1 << CoordW) - 1;

  typedef enum logic [1:0] {JobQuery, JobWrite, JobPause} job_kind_e;

  typedef struct {
    job_kind_e          kind;
    int unsigned        gap;
    coord_t             tcol;
    coord_t             trow;
    logic [FromW-1:0]   fcol;
    logic [FromW-1:0]   frow;
    cfg_idx_t           index;
    logic [CfgDataW-1:0] data;
  } job_t;

  typedef struct {
    cost_out_t cost;
    logic      unr;
  } move_cost_t;

  logic                      clk_i        = 1'b0;
  logic                      rst_ni       = 1'b0;
  logic                      start        = 1'b0;
  logic                      busy;
  logic [TargetW-1:0]        target_col_i = '0;
  logic [TargetW-1:0]        target_row_i = '0;
  logic signed [FromW-1:0]   from_col_i   = '0;
  logic signed [FromW-1:0]   from_row_i   = '0;
  logic                      done_o;
  logic [CostOutW-1:0]       cost_o;
  logic                      unreachable_o;
  logic                      cfg_valid_i  = 1'b0;
  logic                      cfg_ready_o;
  cfg_idx_t                  cfg_index_i  = RegCapFlags;
  logic [CfgDataW-1:0]       cfg_data_i   = '0;

  // Configuration as the block should hold it
  logic [CapW-1:0]  caps_q;
  logic [VertW-1:0] vert_q;
  logic [HorzW-1:0] horz_q;
  coord_t           tab_q;
  coord_t           cols_q;

  job_t        pending_jobs[$];
  move_cost_t  cost_due[$];
  job_t        cur_job;
  logic        job_loaded;
  logic        drive_start;
  logic        drive_cfg;
  logic        stim_done = 1'b0;
  int unsigned hold_cnt;
  int unsigned queries_sent;
  int unsigned results_seen;
  int unsigned idle_cycles;
  int unsigned errors = 0;
  logic        steady = 1'b0;

  cursor_motion_cost u_top (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Cost of the relative move, -1 when some needed motion is missing.
  function automatic longint relative_cost(longint x, longint y, longint ox, longint oy);
    longint c_lf, c_dn, c_up, c_mup, c_rt, c_lt, c_bs, c_tb, c_bt;
    longint tw, co, cost, delta, mult, ntabs, under, over;
    logic   bs, under_ok, over_ok;
    c_lf  = vert_q[VcLf*CostFieldW +: CostFieldW];
    c_dn  = vert_q[VcMultiDown*CostFieldW +: CostFieldW];
    c_up  = vert_q[VcUp*CostFieldW +: CostFieldW];
    c_mup = vert_q[VcMultiUp*CostFieldW +: CostFieldW];
    c_rt  = horz_q[HcMultiRight*CostFieldW +: CostFieldW];
    c_lt  = horz_q[HcMultiLeft*CostFieldW +: CostFieldW];
    c_bs  = horz_q[HcBackspace*CostFieldW +: CostFieldW];
    c_tb  = horz_q[HcTab*CostFieldW +: CostFieldW];
    c_bt  = horz_q[HcBacktab*CostFieldW +: CostFieldW];
    tw    = tab_q;
    co    = cols_q;
    bs    = caps_q[CapBackspace];
    cost  = 0;
    if (tw == 0) tw = 1;

    if (y > oy) begin
      delta = y - oy;
      if (caps_q[CapLf]) begin
        mult = delta * c_lf;
        if (delta < NearDist && c_dn < mult) cost += c_dn;
        else if (delta >= NearDist && c_dn + 1 < mult) cost += c_dn + 1;
        else cost += mult;
      end else if (caps_q[CapMultiDown]) begin
        cost += (delta < NearDist) ? c_dn : c_dn + 1;
      end else begin
        return -1;
      end
    end else if (y < oy) begin
      delta = oy - y;
      if (caps_q[CapUp]) begin
        mult = delta * c_up;
        if (delta < NearDist && c_mup < mult) cost += c_mup;
        else if (delta >= NearDist && c_mup < mult) cost += c_mup + 1;
        else cost += mult;
      end else if (caps_q[CapMultiUp]) begin
        cost += (delta < NearDist) ? c_mup : c_mup + 1;
      end else begin
        return -1;
      end
    end

    if (x > ox && caps_q[CapTab]) begin
      delta = x - ox;
      ntabs = (delta + ox % tw) / tw;
      under = x % tw + c_tb * ntabs;
      if (x + tw < co && bs) over = c_bs * (tw - x % tw) + c_tb * (ntabs + 1);
      else over = UnreachCost;
      if (delta < NearDist && under < c_rt && under < delta && over > under) return cost + under;
      if (under < c_rt + 1 && under < delta && over > under) return cost + under;
      if (delta < NearDist && over < c_rt && over < delta) return cost + over;
      if (over < c_rt + 1 && over < delta) return cost + over;
    end else if (x < ox && caps_q[CapBacktab]) begin
      delta    = ox - x;
      ntabs    = (delta + tw - ox % tw) / tw;
      under    = bs ? c_bt * ntabs + c_bs * (tw - x % tw) : UnreachCost;
      over     = (x - tw >= 0) ? c_bt * (ntabs + 1) + x % tw : UnreachCost;
      under_ok = bs ? (under < delta * c_bs) : 1'b1;
      over_ok  = bs ? (over < delta * c_bs) : 1'b1;
      if (delta < NearDist && under < c_lt && under_ok && over > under) return cost + under;
      if (under < c_lt + 1 && under_ok && over > under) return cost + under;
      // back-tab overshoot is weighed against the multi-right cost
      if (delta < NearDist && over < c_rt && over_ok) return cost + over;
      if (over < c_rt + 1 && over_ok) return cost + over;
    end

    if (x < ox) begin
      delta = ox - x;
      if (bs) begin
        mult = delta * c_bs;
        if (c_lt < mult && delta < NearDist) cost += c_lt;
        else if (c_lt + 1 < mult) cost += c_lt + 1;
        else cost += mult;
      end else if (caps_q[CapMultiLeft]) begin
        cost += c_lt;
      end else begin
        return -1;
      end
    end else if (x > ox) begin
      delta = x - ox;
      if (c_rt < delta && delta < NearDist) cost += c_rt;
      else if (c_rt + 1 < delta) cost += c_rt + 1;
      else cost += delta;
    end
    return cost;
  endfunction

  function automatic move_cost_t motion_estimate(coord_t tcol, coord_t trow,
                                                 logic [FromW-1:0] fcol,
                                                 logic [FromW-1:0] frow);
    move_cost_t r;
    longint     c;
    if (fcol[FromW-1] || frow[FromW-1]) c = -1;
    else c = relative_cost(tcol, trow, fcol[CoordW-1:0], frow[CoordW-1:0]);
    if (c < 0) begin
      r.cost = cost_out_t'(UnreachCost);
      r.unr  = 1'b1;
    end else begin
      r.cost = cost_out_t'(c);
      r.unr  = 1'b0;
    end
    return r;
  endfunction

  function automatic int unsigned draw_gap();
    return steady ? 0 : $urandom_range(0, 9);
  endfunction

  task automatic push_query(coord_t tcol, coord_t trow, logic [FromW-1:0] fcol,
                            logic [FromW-1:0] frow);
    job_t j;
    j.kind  = JobQuery;
    j.gap   = draw_gap();
    j.tcol  = tcol;
    j.trow  = trow;
    j.fcol  = fcol;
    j.frow  = frow;
    j.index = RegCapFlags;
    j.data  = '0;
    pending_jobs.push_back(j);
  endtask

  task automatic push_write(cfg_idx_t index, logic [CfgDataW-1:0] data);
    job_t j;
    j.kind  = JobWrite;
    j.gap   = draw_gap();
    j.tcol  = '0;
    j.trow  = '0;
    j.fcol  = '0;
    j.frow  = '0;
    j.index = index;
    j.data  = data;
    pending_jobs.push_back(j);
  endtask

  task automatic push_pause();
    job_t j;
    j.kind  = JobPause;
    j.gap   = draw_gap();
    j.tcol  = '0;
    j.trow  = '0;
    j.fcol  = '0;
    j.frow  = '0;
    j.index = RegCapFlags;
    j.data  = '0;
    pending_jobs.push_back(j);
  endtask

  task automatic load_setting(logic [CapW-1:0] caps, logic [VertW-1:0] vert,
                              logic [HorzW-1:0] horz, coord_t tw, coord_t cols);
    push_write(RegCapFlags, CfgDataW'(caps));
    push_write(RegVertCosts, CfgDataW'(vert));
    push_write(RegHorzCosts, CfgDataW'(horz));
    push_write(RegTabWidth, CfgDataW'(tw));
    push_write(RegScreenCols, CfgDataW'(cols));
  endtask

  function automatic logic [HorzW-1:0] draw_costs();
    logic [HorzW-1:0] v;
    int unsigned      span;
    v = '0;
    for (int i = 0; i < 5; i++) begin
      case ($urandom_range(0, 3))
        0:       span = 40;
        1:       span = (1 << CostFieldW) - 1;
        default: span = 6;
      endcase
      v[i*CostFieldW +: CostFieldW] = cost_t'($urandom_range(0, span));
    end
    return v;
  endfunction

  function automatic logic [FromW-1:0] near_coord(int base, int span);
    int v;
    v = base + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > CoordMax) v = CoordMax;
    return FromW'(v);
  endfunction

  // Driver: one transaction at a time, writes and pauses wait for the pipe to drain
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start        <= 1'b0;
      cfg_valid_i  <= 1'b0;
      stim_done    <= 1'b0;
      job_loaded   = 1'b0;
      hold_cnt     = 0;
      queries_sent = 0;
    end else begin
      drive_start = start;
      drive_cfg   = cfg_valid_i;
      if (start && !busy) begin
        drive_start  = 1'b0;
        queries_sent = queries_sent + 1;
      end
      if (cfg_valid_i && cfg_ready_o) drive_cfg = 1'b0;
      if (!job_loaded && pending_jobs.size() != 0) begin
        cur_job    = pending_jobs.pop_front();
        job_loaded = 1'b1;
        hold_cnt   = cur_job.gap;
      end
      if (job_loaded && !drive_start && !drive_cfg) begin
        if (cur_job.kind != JobQuery && queries_sent != results_seen) begin
          hold_cnt = cur_job.gap;
        end else if (hold_cnt != 0) begin
          hold_cnt = hold_cnt - 1;
        end else begin
          case (cur_job.kind)
            JobQuery: begin
              target_col_i <= cur_job.tcol;
              target_row_i <= cur_job.trow;
              from_col_i   <= cur_job.fcol;
              from_row_i   <= cur_job.frow;
              drive_start  = 1'b1;
            end
            JobWrite: begin
              cfg_index_i <= cur_job.index;
              cfg_data_i  <= cur_job.data;
              drive_cfg   = 1'b1;
            end
            default: ;
          endcase
          job_loaded = 1'b0;
        end
      end
      start       <= drive_start;
      cfg_valid_i <= drive_cfg;
      stim_done   <= !job_loaded && pending_jobs.size() == 0 && !drive_start && !drive_cfg;
    end
  end

  // Monitor: track register writes, predict each accepted query, check each result
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    move_cost_t want;
    if (!rst_ni) begin
      caps_q       = '0;
      vert_q       = '0;
      horz_q       = '0;
      tab_q        = coord_t'(TabReset);
      cols_q       = coord_t'(ColsReset);
      results_seen <= 0;
    end else begin
      if (done_o) begin
        results_seen <= results_seen + 1;
        if (cost_due.size() == 0) begin
          $display("%0t unexpected result: cost %0d unreachable %0b",
                   $time, cost_o, unreachable_o);
          errors++;
        end else begin
          want = cost_due.pop_front();
          if (cost_o !== want.cost) begin
            $display("%0t cost mismatch: expected %0d actual %0d", $time, want.cost, cost_o);
            errors++;
          end
          if (unreachable_o !== want.unr) begin
            $display("%0t unreachable mismatch: expected %0b actual %0b",
                     $time, want.unr, unreachable_o);
            errors++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          RegCapFlags:   caps_q = cfg_data_i[CapW-1:0];
          RegVertCosts:  vert_q = cfg_data_i[VertW-1:0];
          RegHorzCosts:  horz_q = cfg_data_i[HorzW-1:0];
          RegTabWidth:   tab_q  = cfg_data_i[TabW-1:0];
          RegScreenCols: cols_q = cfg_data_i[ColsW-1:0];
          default: ;
        endcase
      end
      if (start && !busy)
        cost_due.push_back(motion_estimate(target_col_i, target_row_i, from_col_i, from_row_i));
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || (cfg_valid_i && cfg_ready_o) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IdleLimit) begin
      $display("%0t no transaction for %0d cycles", $time, IdleLimit);
      $display("cursor_motion_cost regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [CapW-1:0]  caps_w;
    logic [HorzW-1:0] vert_w;
    logic [HorzW-1:0] horz_w;
    coord_t           tw_w;
    coord_t           cols_w;
    coord_t           tcol;
    coord_t           trow;
    logic [FromW-1:0] fcol;
    logic [FromW-1:0] frow;

    // Reset defaults: no capabilities at all
    push_query(10, 5, 10, 2);
    push_query(10, 5, 10, 9);
    push_query(3, 5, 20, 5);
    push_query(40, 5, 20, 5);
    push_query(0, 0, 0, 0);

    load_setting(8'hFF, {12'd4, 12'd1, 12'd4, 12'd1},
                 {12'd2, 12'd1, 12'd1, 12'd4, 12'd4}, 8, 80);
    push_query(5, 5, 9'h1FF, 5);
    push_query(5, 5, 5, 9'h100);
    push_query(255, 255, 0, 0);
    push_query(0, 0, 255, 255);
    push_query(10, 8, 10, 5);
    push_query(10, 20, 10, 5);
    push_query(10, 5, 10, 8);
    push_query(10, 5, 10, 20);
    push_query(20, 0, 1, 0);
    push_query(15, 0, 3, 0);
    push_query(5, 0, 30, 0);
    push_query(2, 0, 70, 0);
    push_query(76, 0, 74, 0);

    // tab width of zero acts as one
    push_write(RegTabWidth, '0);
    push_query(7, 0, 2, 0);
    push_query(3, 0, 9, 0);

    // tabs only: vertical and left motions are missing
    push_write(RegCapFlags, CfgDataW'(8'h10));
    push_write(RegTabWidth, CfgDataW'(8));
    push_query(10, 9, 10, 3);
    push_query(10, 2, 10, 9);
    push_query(3, 0, 40, 0);
    push_query(40, 0, 3, 0);
    push_pause();

    for (int phase = 0; phase < PhaseCount; phase++) begin
      case (phase)
        0: begin
          caps_w = '1; vert_w = '1; horz_w = '1; tw_w = '1; cols_w = '1;
        end
        1: begin
          caps_w = '1; vert_w = '0; horz_w = '0; tw_w = 1; cols_w = 8;
        end
        default: begin
          caps_w = ($urandom_range(0, 3) == 0) ? CapW'($urandom)
                                               : 8'hFF & ~(8'h01 << $urandom_range(0, 8));
          vert_w = draw_costs();
          horz_w = draw_costs();
          case ($urandom_range(0, 5))
            0:       tw_w = 0;
            1:       tw_w = 1;
            2:       tw_w = '1;
            default: tw_w = coord_t'($urandom_range(2, 16));
          endcase
          case ($urandom_range(0, 3))
            0:       cols_w = 8;
            1:       cols_w = '1;
            default: cols_w = coord_t'($urandom_range(8, CoordMax));
          endcase
        end
      endcase
      load_setting(caps_w, vert_w[VertW-1:0], horz_w, tw_w, cols_w);

      for (int n = 0; n < PhaseItems; n++) begin
        if ($urandom_range(0, 39) == 0) steady = !steady;
        tcol = ($urandom_range(0, 4) != 0) ? coord_t'($urandom_range(0, cols_w - 1))
                                           : coord_t'($urandom);
        trow = ($urandom_range(0, 4) != 0) ? coord_t'($urandom_range(0, 50))
                                           : coord_t'($urandom);
        if ($urandom_range(0, 9) < 6) begin
          fcol = near_coord(tcol, 12);
          frow = near_coord(trow, 14);
        end else begin
          fcol = FromW'($urandom_range(0, CoordMax));
          frow = FromW'($urandom_range(0, CoordMax));
        end
        if ($urandom_range(0, 5) == 0) frow = FromW'(trow);
        // unknown start: any value with the sign bit set
        if ($urandom_range(0, 24) == 0) begin
          if ($urandom_range(0, 1) != 0) fcol[FromW-1] = 1'b1;
          else frow[FromW-1] = 1'b1;
        end
        push_query(tcol, trow, fcol, frow);
        if ($urandom_range(0, 99) == 0) push_pause();
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (stim_done);
    do @(posedge clk_i); while (cost_due.size() != 0);
    repeat (Latency + 4) @(posedge clk_i);
    if (cost_due.size() != 0) begin
      $display("%0t %0d expected results never arrived", $time, cost_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("cursor_motion_cost regression: pass");
    end else begin
      $display("cursor_motion_cost regression: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/cmc_pkg.sv
rtl/cmc_vertical.sv
rtl/cmc_divider.sv
rtl/cmc_horizontal.sv
rtl/cursor_motion_cost.sv
rtl/cmc_checker.sv
test/cursor_motion_cost_test.sv
